// ===== hw/rtl/gtb_pkg.sv =====
// ----------------------------------------------------------------------------
// gtb_pkg: shared constants for the glyph text blitter
// Action codes, register indexes, reset values, glyph cell geometry.
// ----------------------------------------------------------------------------
package gtb_pkg;

	localparam int GLYPH_COUNT_DEF = 256;
	localparam int GLYPH_ROWS_DEF  = 8;

	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CUR_W     = 14;
	localparam int ADDR_W    = 24;
	localparam int COLOR_W   = 32;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_BEGIN = 2'd1;
	localparam logic [1:0] ACT_DRAW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_COLS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_ROWS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_COLS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_ROWS = 3'd5;

	localparam logic [CFG_W-1:0] WIN_LEFT_RST = 12'd0;
	localparam logic [CFG_W-1:0] WIN_TOP_RST  = 12'd0;
	localparam logic [CFG_W-1:0] WIN_COLS_RST = 12'd640;
	localparam logic [CFG_W-1:0] WIN_ROWS_RST = 12'd480;
	localparam logic [CFG_W-1:0] SCR_COLS_RST = 12'd640;
	localparam logic [CFG_W-1:0] SCR_ROWS_RST = 12'd480;

	localparam logic [CUR_W-1:0] CELL_W     = 14'd8;
	localparam logic [CUR_W-1:0] CELL_H     = 14'd8;
	localparam logic [CUR_W-1:0] LINE_PITCH = 14'd10;
	localparam logic [7:0]       NEWLINE_CODE = 8'd10;

endpackage

// ===== hw/rtl/glyph_text_blitter_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_text_blitter_unit: 8x8 bitmap font text renderer
// Emits clipped framebuffer pixel writes for each drawn character.
// ----------------------------------------------------------------------------
// A load or begin request, an action-3 request and a draw after stop each
// give one status result. A draw walks the glyph row by row: the read state
// fetches the row from the font memory (single port, registered read) and
// computes the row's framebuffer base, then the scan state tests the eight
// pixels left to right, stalling while the result side holds back a write.
// Each write is held back until the next set pixel is found, so that the
// final one can carry last_of_run.
module glyph_text_blitter_unit #(
	parameter int GLYPH_COUNT = gtb_pkg::GLYPH_COUNT_DEF,
	parameter int GLYPH_ROWS  = gtb_pkg::GLYPH_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gtb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gtb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [1:0]                       action,
	input  logic [7:0]                       char_code,
	input  logic [2:0]                       glyph_row_index,
	input  logic [7:0]                       glyph_row_bits,
	input  logic [gtb_pkg::CFG_W-1:0]        start_col,
	input  logic [gtb_pkg::CFG_W-1:0]        start_row,
	input  logic [gtb_pkg::COLOR_W-1:0]      ink_color,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic                             write_valid,
	output logic [gtb_pkg::ADDR_W-1:0]       pixel_address,
	output logic [gtb_pkg::COLOR_W-1:0]      pixel_color,
	output logic                             text_stopped,
	output logic                             last_of_run
);
	import gtb_pkg::*;

	localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FA_W       = $clog2(FONT_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [CFG_W-1:0] win_left_q, win_top_q, win_cols_q, win_rows_q;
	logic [CFG_W-1:0] scr_cols_q, scr_rows_q;

	logic [1:0]         state_q;
	logic [2:0]         dy_q, dx_q;
	logic [7:0]         code_q;
	logic               code_ok_q;
	logic [CUR_W-1:0]   cur_col_q, cur_row_q;
	logic [CFG_W-1:0]   line_col_q;
	logic [COLOR_W-1:0] ink_q;
	logic               stop_q;

	logic [7:0]         font_mem [FONT_DEPTH];
	logic [7:0]         rd_data_q;
	logic [ADDR_W-1:0]  row_base_q;
	logic               row_ok_q;

	logic               pend_valid_q;
	logic [ADDR_W-1:0]  pend_addr_q;

	logic               out_valid_q, out_write_q, out_stop_q, out_last_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [COLOR_W-1:0] out_color_q;

	logic               accept, slot_free, start_draw, load_we;
	logic               scan_emit, scan_stall, fin_go, hit;
	logic [FA_W-1:0]    wr_addr, rd_addr;
	logic [14:0]        wy, sy, wx, sx;
	logic [ADDR_W-1:0]  hit_addr;
	logic [CUR_W-1:0]   col8, nxt_col, nxt_row, row_pitch;
	logic               wrap, nxt_stop;

	assign slot_free  = !out_valid_q || result_ready;
	assign item_ready = (state_q == ST_IDLE) && slot_free;
	assign accept     = item_valid && item_ready;
	assign start_draw = accept && (action == ACT_DRAW) && !stop_q;
	assign load_we    = accept && (action == ACT_LOAD)
		&& (9'(char_code) < 9'(GLYPH_COUNT)) && (5'(glyph_row_index) < 5'(GLYPH_ROWS));

	assign wr_addr = FA_W'(FA_W'(char_code) * FA_W'(GLYPH_ROWS) + FA_W'(glyph_row_index));
	assign rd_addr = FA_W'(FA_W'(code_q) * FA_W'(GLYPH_ROWS) + FA_W'(dy_q));

	// row geometry, used in ST_RD
	assign wy = 15'(cur_row_q) + 15'(dy_q);
	assign sy = 15'(win_top_q) + wy;

	// pixel geometry, used in ST_SCAN
	assign wx       = 15'(cur_col_q) + 15'(dx_q);
	assign sx       = 15'(win_left_q) + wx;
	assign hit_addr = row_base_q + ADDR_W'(sx);
	assign hit      = code_ok_q && row_ok_q && rd_data_q[3'd7 - dx_q]
		&& (wx < 15'(win_cols_q)) && (sx < 15'(scr_cols_q));

	assign scan_emit  = (state_q == ST_SCAN) && hit && pend_valid_q;
	assign scan_stall = scan_emit && !slot_free;
	assign fin_go     = (state_q == ST_FIN) && slot_free;

	// cursor after the current character
	assign row_pitch = cur_row_q + LINE_PITCH;
	assign col8      = cur_col_q + CELL_W;
	assign wrap      = (code_q == NEWLINE_CODE) || ((15'(col8) + 15'(CELL_W)) >= 15'(win_cols_q));
	assign nxt_col   = wrap ? CUR_W'(line_col_q) : col8;
	assign nxt_row   = wrap ? row_pitch : cur_row_q;
	assign nxt_stop  = (15'(nxt_row) + 15'(CELL_H)) >= 15'(win_rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q <= WIN_LEFT_RST;
			win_top_q  <= WIN_TOP_RST;
			win_cols_q <= WIN_COLS_RST;
			win_rows_q <= WIN_ROWS_RST;
			scr_cols_q <= SCR_COLS_RST;
			scr_rows_q <= SCR_ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIN_LEFT: win_left_q <= cfg_data;
				REG_WIN_TOP:  win_top_q  <= cfg_data;
				REG_WIN_COLS: win_cols_q <= cfg_data;
				REG_WIN_ROWS: win_rows_q <= cfg_data;
				REG_SCR_COLS: scr_cols_q <= cfg_data;
				REG_SCR_ROWS: scr_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			font_mem[wr_addr] <= glyph_row_bits;
		end
		if (state_q == ST_RD) begin
			rd_data_q <= font_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			row_base_q <= ADDR_W'(sy[11:0]) * ADDR_W'(scr_cols_q);
			row_ok_q   <= (wy < 15'(win_rows_q)) && (sy < 15'(scr_rows_q));
		end
		if (start_draw) begin
			code_q    <= char_code;
			code_ok_q <= 9'(char_code) < 9'(GLYPH_COUNT);
		end
		if ((state_q == ST_SCAN) && hit && !scan_stall) begin
			pend_addr_q <= hit_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dy_q         <= '0;
			dx_q         <= '0;
			pend_valid_q <= 1'b0;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			line_col_q   <= '0;
			ink_q        <= '0;
			stop_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (action == ACT_BEGIN)) begin
						cur_col_q  <= CUR_W'(start_col);
						cur_row_q  <= CUR_W'(start_row);
						line_col_q <= start_col;
						ink_q      <= ink_color;
						stop_q     <= 1'b0;
					end
					if (start_draw) begin
						state_q      <= ST_RD;
						dy_q         <= '0;
						dx_q         <= '0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_RD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						dx_q <= dx_q + 3'd1;
						if (dx_q == 3'd7) begin
							dy_q    <= dy_q + 3'd1;
							state_q <= (dy_q == 3'd7) ? ST_FIN : ST_RD;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						cur_col_q    <= nxt_col;
						cur_row_q    <= nxt_row;
						stop_q       <= nxt_stop;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= (accept && !start_draw) || scan_emit || fin_go;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			priority if (accept && !start_draw) begin
				out_write_q <= 1'b0;
				out_addr_q  <= '0;
				out_color_q <= '0;
				out_stop_q  <= (action == ACT_BEGIN) ? 1'b0 : stop_q;
				out_last_q  <= 1'b1;
			end else if (scan_emit) begin
				out_write_q <= 1'b1;
				out_addr_q  <= pend_addr_q;
				out_color_q <= ink_q;
				out_stop_q  <= nxt_stop;
				out_last_q  <= 1'b0;
			end else if (fin_go) begin
				out_write_q <= pend_valid_q;
				out_addr_q  <= pend_valid_q ? pend_addr_q : '0;
				out_color_q <= pend_valid_q ? ink_q : '0;
				out_stop_q  <= nxt_stop;
				out_last_q  <= 1'b1;
			end else begin
				out_last_q  <= out_last_q;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign write_valid   = out_write_q;
	assign pixel_address = out_addr_q;
	assign pixel_color   = out_color_q;
	assign text_stopped  = out_stop_q;
	assign last_of_run   = out_last_q;

	a_null_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !write_valid |-> last_of_run)
		else $error("status result not marked last");

	a_null_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !write_valid |-> (pixel_address == '0) && (pixel_color == '0))
		else $error("status result carries payload");

	a_pend_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> state_q != ST_IDLE)
		else $error("pending write outside a draw");

	a_fin_closes: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (state_q == ST_IDLE) && result_valid && last_of_run)
		else $error("draw did not close with a last result");

endmodule
